/* sv/imhq_pkg.sv */
`default_nettype none
package imhq_pkg;

  localparam int CAPACITY  = 256;
  localparam int KEY_BITS  = 32;
  localparam int TAG_BITS  = 8;
  localparam int TAG_SPACE = 1 << TAG_BITS;
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  typedef logic [1:0] op_t;
  localparam op_t OP_PUSH   = 2'd0;
  localparam op_t OP_POP    = 2'd1;
  localparam op_t OP_DELETE = 2'd2;
  localparam op_t OP_NOP    = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_FULL    = 3'd1;
  localparam status_t ST_EMPTY   = 3'd2;
  localparam status_t ST_PRESENT = 3'd3;
  localparam status_t ST_ABSENT  = 3'd4;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_PUSH, S_RM_START, S_RM_LAST,
    S_UP_RD, S_UP_CMP, S_DOWN_RD, S_DOWN_CMP, S_FINISH
  } ctl_state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_CHECK, CMD_PUSH, CMD_REMOVE_START, CMD_LOAD_LAST,
    CMD_READ_PARENT, CMD_MOVE_PARENT, CMD_READ_CHILD, CMD_MOVE_CHILD,
    CMD_PLACE, CMD_EMIT
  } dp_cmd_t;

  typedef struct packed {
    status_t err;
    op_t     op;
    logic    hole_root;
    logic    hole_last;
    logic    up_gt;
    logic    first;
    logic    dn_move;
    logic    out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* sv/imhq_ctrl.sv */
`default_nettype none
module imhq_ctrl import imhq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        if (stat.err != ST_OK || stat.op == OP_NOP) state_nxt = S_FINISH;
        else if (stat.op == OP_PUSH) state_nxt = S_PUSH;
        else state_nxt = S_RM_START;
      end
      S_PUSH:     state_nxt = S_UP_RD;
      S_RM_START: state_nxt = S_RM_LAST;
      S_RM_LAST:  state_nxt = stat.hole_last ? S_FINISH : S_UP_RD;
      S_UP_RD: begin
        if (!stat.hole_root) state_nxt = S_UP_CMP;
        else if (stat.first) state_nxt = S_DOWN_RD;
        else state_nxt = S_FINISH;
      end
      S_UP_CMP: begin
        if (stat.up_gt) state_nxt = S_UP_RD;
        else if (stat.first) state_nxt = S_DOWN_RD;
        else state_nxt = S_FINISH;
      end
      S_DOWN_RD:  state_nxt = S_DOWN_CMP;
      S_DOWN_CMP: state_nxt = stat.dn_move ? S_DOWN_RD : S_FINISH;
      S_FINISH:   if (stat.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = CMD_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = CMD_LOAD;
      end
      S_DECODE:   cmd = CMD_CHECK;
      S_PUSH:     cmd = CMD_PUSH;
      S_RM_START: cmd = CMD_REMOVE_START;
      S_RM_LAST:  cmd = CMD_LOAD_LAST;
      S_UP_RD: begin
        if (!stat.hole_root) cmd = CMD_READ_PARENT;
        else if (!stat.first) cmd = CMD_PLACE;
      end
      S_UP_CMP: begin
        if (stat.up_gt) cmd = CMD_MOVE_PARENT;
        else if (!stat.first) cmd = CMD_PLACE;
      end
      S_DOWN_RD:  cmd = CMD_READ_CHILD;
      S_DOWN_CMP: cmd = stat.dn_move ? CMD_MOVE_CHILD : CMD_PLACE;
      S_FINISH:   if (stat.out_free) cmd = CMD_EMIT;
      default:    cmd = CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

/* sv/imhq_dp.sv */
`default_nettype none
module imhq_dp import imhq_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dp_cmd_t             cmd,
  input  wire logic [1:0]          in_op,
  input  wire logic [KEY_BITS-1:0] in_key,
  input  wire logic [TAG_BITS-1:0] in_tag,
  input  wire logic                out_ready,
  output dp_stat_t                 stat,
  output logic                     out_valid,
  output logic                     out_top_valid,
  output logic [KEY_BITS-1:0]      out_top_key,
  output logic [TAG_BITS-1:0]      out_top_tag,
  output logic [CNT_BITS-1:0]      out_entry_count,
  output logic [2:0]               out_status
);

  // storage
  slot_t               slot_mem [CAPACITY];
  logic [IDX_BITS-1:0] pos_mem  [TAG_SPACE];
  logic [TAG_SPACE-1:0] present_r;

  // item and walk registers
  op_t                 op_r;
  slot_t               cur_r;
  logic [IDX_BITS-1:0] hole_r;
  logic [CNT_BITS-1:0] n_r;
  logic                first_r;
  status_t             status_r;
  slot_t               top_r;
  slot_t               rd_a_r, rd_b_r;
  logic [IDX_BITS-1:0] pos_rd_r;

  logic                out_valid_r, out_top_valid_r;
  logic [KEY_BITS-1:0] out_key_r;
  logic [TAG_BITS-1:0] out_tag_r;
  logic [CNT_BITS-1:0] out_cnt_r;
  status_t             out_status_r;

  logic [IDX_BITS-1:0] parent_idx, ra_addr, rb_addr, rm_pos, w_addr;
  logic [IDX_BITS:0]   left_idx, right_idx;
  logic                l_ok, r_ok, slot_we;
  slot_t               w_data, child;
  status_t             err;

  assign parent_idx = (hole_r - IDX_BITS'(1)) >> 1;
  assign left_idx   = {hole_r, 1'b1};
  assign right_idx  = left_idx + (IDX_BITS+1)'(1);

  // left wins ties against the right child
  assign l_ok  = ({1'b0, left_idx} < (IDX_BITS+2)'(n_r)) &&
                 ($signed(rd_a_r.key) > $signed(cur_r.key));
  assign r_ok  = ({1'b0, right_idx} < (IDX_BITS+2)'(n_r)) &&
                 ($signed(rd_b_r.key) > $signed(l_ok ? rd_a_r.key : cur_r.key));
  assign child = r_ok ? rd_b_r : rd_a_r;

  assign rm_pos = (op_r == OP_POP) ? '0 : pos_rd_r;

  always_comb begin
    err = ST_OK;
    unique case (op_r)
      OP_PUSH: begin
        if (n_r == CNT_BITS'(CAPACITY)) err = ST_FULL;
        else if (present_r[cur_r.tag]) err = ST_PRESENT;
      end
      OP_POP:    if (n_r == '0) err = ST_EMPTY;
      OP_DELETE: begin
        if (n_r == '0) err = ST_EMPTY;
        else if (!present_r[cur_r.tag]) err = ST_ABSENT;
      end
      default:   err = ST_OK;
    endcase
  end

  always_comb begin
    stat.err       = err;
    stat.op        = op_r;
    stat.hole_root = (hole_r == '0);
    stat.hole_last = ({1'b0, hole_r} == n_r);
    stat.up_gt     = $signed(cur_r.key) > $signed(rd_a_r.key);
    stat.first     = first_r;
    stat.dn_move   = l_ok || r_ok;
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    ra_addr = left_idx[IDX_BITS-1:0];
    unique case (cmd)
      CMD_REMOVE_START: ra_addr = IDX_BITS'(n_r - CNT_BITS'(1));
      CMD_READ_PARENT:  ra_addr = parent_idx;
      default:          ra_addr = left_idx[IDX_BITS-1:0];
    endcase
  end
  assign rb_addr = right_idx[IDX_BITS-1:0];

  always_comb begin
    slot_we = 1'b0;
    w_addr  = hole_r;
    w_data  = cur_r;
    unique case (cmd)
      CMD_MOVE_PARENT: begin
        slot_we = 1'b1;
        w_data  = rd_a_r;
      end
      CMD_MOVE_CHILD: begin
        slot_we = 1'b1;
        w_data  = child;
      end
      CMD_PLACE:       slot_we = 1'b1;
      default:         slot_we = 1'b0;
    endcase
  end

  // memories: one write port, registered reads
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[w_addr]       <= w_data;
      pos_mem[w_data.tag]    <= w_addr;
    end
    rd_a_r   <= slot_mem[ra_addr];
    rd_b_r   <= slot_mem[rb_addr];
    pos_rd_r <= pos_mem[cur_r.tag];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (slot_we && w_addr == '0) top_r <= w_data;
    unique case (cmd)
      CMD_LOAD: begin
        op_r      <= in_op;
        cur_r.key <= in_key;
        cur_r.tag <= in_tag;
      end
      CMD_CHECK:        status_r <= err;
      CMD_PUSH:         hole_r <= n_r[IDX_BITS-1:0];
      CMD_REMOVE_START: hole_r <= rm_pos;
      CMD_LOAD_LAST:    cur_r  <= rd_a_r;
      CMD_MOVE_PARENT:  hole_r <= parent_idx;
      CMD_MOVE_CHILD:   hole_r <= r_ok ? right_idx[IDX_BITS-1:0] : left_idx[IDX_BITS-1:0];
      CMD_EMIT: begin
        out_top_valid_r <= (n_r != '0);
        out_key_r       <= (n_r != '0) ? top_r.key : '0;
        out_tag_r       <= (n_r != '0) ? top_r.tag : '0;
        out_cnt_r       <= n_r;
        out_status_r    <= status_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= '0;
      n_r         <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (cmd)
        CMD_PUSH: begin
          present_r[cur_r.tag] <= 1'b1;
          n_r                  <= n_r + CNT_BITS'(1);
          first_r              <= 1'b0;
        end
        CMD_REMOVE_START: begin
          present_r[(op_r == OP_POP) ? top_r.tag : cur_r.tag] <= 1'b0;
          n_r <= n_r - CNT_BITS'(1);
        end
        CMD_LOAD_LAST:   first_r <= 1'b1;
        CMD_MOVE_PARENT: first_r <= 1'b0;
        default: ;
      endcase
      if (cmd == CMD_EMIT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_top_valid   = out_top_valid_r;
  assign out_top_key     = out_key_r;
  assign out_top_tag     = out_tag_r;
  assign out_entry_count = out_cnt_r;
  assign out_status      = out_status_r;

endmodule
`default_nettype wire

/* sv/indexed_max_heap_queue_core.sv */
// Indexed max-heap queue: push / pop / delete-by-tag, one result item per input item.
// A rejected or no-op item goes from decode straight to the result; a sift does a read
// step and then a compare step at each level, moving the hole up or down the heap.
// One item at a time: the next item is taken the cycle after the result is registered,
// and the result waits in the finish state while the output is stalled.
// Reset (rst_n, synchronous, active low) clears the count, the tag-present bits and the
// output valid; slot and position memories are not cleared.
`default_nettype none
module indexed_max_heap_queue_core import imhq_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_op,
  input  wire logic [KEY_BITS-1:0] in_key,
  input  wire logic [TAG_BITS-1:0] in_tag,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_top_valid,
  output logic [KEY_BITS-1:0]      out_top_key,
  output logic [TAG_BITS-1:0]      out_top_tag,
  output logic [CNT_BITS-1:0]      out_entry_count,
  output logic [2:0]               out_status
);

  // The controller sequences each item: decode and check, then for an accepted push, pop
  // or delete a hole-based sift (the moving entry stays in a register, displaced entries
  // are written into the hole, and the entry lands once at the end). The datapath owns the
  // slot memory, the tag-to-slot memory, the present bits and a shadow copy of the root slot.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  imhq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  imhq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_tag          (in_tag),
    .out_ready       (out_ready),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_top_valid   (out_top_valid),
    .out_top_key     (out_top_key),
    .out_top_tag     (out_top_tag),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

endmodule
`default_nettype wire
